### hdl/sms_pkg.sv
// Shared constants and types for the setup mode selector.
// No dependencies; imported by the top level and its checker.
package sms_pkg;

	localparam int unsigned MODE_COUNT = 12;

	localparam int unsigned MODE_W    = 4;
	localparam int unsigned HOLD_W    = 5;
	localparam int unsigned TIMEOUT_W = 10;
	localparam int unsigned BLINK_W   = 6;
	localparam int unsigned FADE_W    = 9;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned DATA_W    = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd900;
	localparam logic [HOLD_W-1:0]    HOLD_RESET    = 5'd16;
	localparam logic [BLINK_W-1:0]   PHASE_B_POINT = 6'd32;

	// Register select bit (paddr[2])
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_HOLD    = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0]    mode_now;
		logic [MODE_W-1:0]    mode_before;
		logic [HOLD_W-1:0]    holdoff;
		logic                 latched;
		logic [TIMEOUT_W-1:0] timeout_left;
		logic                 enabled;
		logic [BLINK_W-1:0]   blink_phase;
		logic [FADE_W-1:0]    fade_timer;
	} sms_state_t;

endpackage

### hdl/setup_mode_selector.sv
// Setup mode selector top level: APB registers, input register, tick logic, result register.
// Depends on sms_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  input     | in_valid / in_ready  | select_pressed, setup_switch_on
//  result    | out_valid / out_ready| current_mode, setup_active, phase_a_pulse,
//            |                      | phase_b_pulse, fade_level, mode_cancelled
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle while out_ready is high; path: input register, result register.
// The tick logic runs once per transaction, between the input register and the result register.
// A stalled result holds the result register; the input register then fills and in_ready drops.
// Reset clears all mode state and loads timeout 900, hold-off 16.
module setup_mode_selector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sms_pkg::ADDR_W-1:0]   paddr,
	input  logic [sms_pkg::DATA_W-1:0]   pwdata,
	output logic [sms_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         select_pressed,
	input  logic                         setup_switch_on,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sms_pkg::MODE_W-1:0]   current_mode,
	output logic                         setup_active,
	output logic                         phase_a_pulse,
	output logic                         phase_b_pulse,
	output logic [1:0]                   fade_level,
	output logic                         mode_cancelled
);
	import sms_pkg::*;

	logic [TIMEOUT_W-1:0] timeout_cfg_q;
	logic [HOLD_W-1:0]    hold_cfg_q;
	logic                 cfg_wr;

	logic valid_s1, sel_s1, sw_s1;
	logic step_go;

	sms_state_t st_q, st_d;
	logic       pa_d, pb_d, canc_d;
	logic [1:0] fade_d;

	logic              out_valid_q;
	logic [MODE_W-1:0] mode_s2;
	logic              active_s2, pa_s2, pb_s2, canc_s2;
	logic [1:0]        fade_s2;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_cfg_q <= TIMEOUT_RESET;
			hold_cfg_q    <= HOLD_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_TIMEOUT: timeout_cfg_q <= pwdata[TIMEOUT_W-1:0];
				REG_HOLD:    hold_cfg_q    <= pwdata[HOLD_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TIMEOUT: prdata = {{(DATA_W-TIMEOUT_W){1'b0}}, timeout_cfg_q};
			REG_HOLD:    prdata = {{(DATA_W-HOLD_W){1'b0}}, hold_cfg_q};
			default:     prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign step_go  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sel_s1 <= select_pressed;
			sw_s1  <= setup_switch_on;
		end
	end

	// ---------------- tick logic ----------------
	function automatic sms_state_t advance(input sms_state_t s, input logic [TIMEOUT_W-1:0] tmo);
		sms_state_t      r;
		logic [MODE_W:0] nxt;
		r = s;
		if (s.mode_now == '0 && s.mode_before != '0)
			nxt = {1'b0, s.mode_before};
		else
			nxt = {1'b0, s.mode_now} + (MODE_W+1)'(1);
		if (nxt >= (MODE_W+1)'(MODE_COUNT)) begin
			r.mode_now    = '0;
			r.mode_before = '0;
		end else begin
			r.mode_now     = nxt[MODE_W-1:0];
			r.timeout_left = tmo;
		end
		r.blink_phase = '0;
		return r;
	endfunction

	always_comb begin
		st_d   = st_q;
		canc_d = 1'b0;
		pa_d   = 1'b0;
		pb_d   = 1'b0;
		fade_d = 2'd0;

		// select button with hold-off
		if (sel_s1) begin
			st_d.holdoff = hold_cfg_q;
			if (!st_d.latched) begin
				st_d.latched = 1'b1;
				st_d = advance(st_d, timeout_cfg_q);
			end
		end else begin
			if (st_d.holdoff != '0)
				st_d.holdoff = st_d.holdoff - HOLD_W'(1);
			if (st_d.holdoff == '0)
				st_d.latched = 1'b0;
		end

		// setup switch: enable on, cancel on release
		if (sw_s1) begin
			st_d.timeout_left = timeout_cfg_q;
			if (!st_d.enabled) begin
				st_d.enabled = 1'b1;
				if (st_d.mode_now == '0)
					st_d = advance(st_d, timeout_cfg_q);
			end
		end else if (st_d.enabled) begin
			st_d.enabled      = 1'b0;
			st_d.mode_before  = st_d.mode_now;
			st_d.mode_now     = '0;
			st_d.timeout_left = '0;
			canc_d            = 1'b1;
		end

		// inactivity timeout
		if (st_d.timeout_left != '0) begin
			st_d.timeout_left = st_d.timeout_left - TIMEOUT_W'(1);
			if (st_d.timeout_left == '0) begin
				st_d.mode_before = st_d.mode_now;
				st_d.mode_now    = '0;
				canc_d           = 1'b1;
			end
		end

		// blink and fade advance only while a mode is active
		if (st_d.mode_now != '0) begin
			pa_d             = (st_d.blink_phase == '0);
			pb_d             = (st_d.blink_phase == PHASE_B_POINT);
			fade_d           = st_d.fade_timer[FADE_W-1:FADE_W-2];
			st_d.fade_timer  = st_d.fade_timer + FADE_W'(1);
			st_d.blink_phase = st_d.blink_phase + BLINK_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_go) begin
			st_q <= st_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			mode_s2   <= st_d.mode_now;
			active_s2 <= st_d.enabled;
			pa_s2     <= pa_d;
			pb_s2     <= pb_d;
			fade_s2   <= fade_d;
			canc_s2   <= canc_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign current_mode   = mode_s2;
	assign setup_active   = active_s2;
	assign phase_a_pulse  = pa_s2;
	assign phase_b_pulse  = pb_s2;
	assign fade_level     = fade_s2;
	assign mode_cancelled = canc_s2;

endmodule

### hdl/sms_checker.sv
// Port-level checker for the setup mode selector, bound to the top level.
// Depends on sms_pkg and setup_mode_selector.
module sms_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sms_pkg::MODE_W-1:0] current_mode,
	input logic                       phase_a_pulse,
	input logic                       phase_b_pulse,
	input logic                       mode_cancelled
);
	import sms_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(current_mode))
		else $error("result changed while stalled");

	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> current_mode < MODE_W'(MODE_COUNT))
		else $error("mode out of range");

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(phase_a_pulse && phase_b_pulse))
		else $error("both phase pulses set");

	a_pulse_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (phase_a_pulse || phase_b_pulse) |-> current_mode != '0)
		else $error("phase pulse while idle");

	a_cancel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_cancelled |-> current_mode == '0)
		else $error("cancel left a mode active");

endmodule

bind setup_mode_selector sms_checker u_sms_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.current_mode   (current_mode),
	.phase_a_pulse  (phase_a_pulse),
	.phase_b_pulse  (phase_b_pulse),
	.mode_cancelled (mode_cancelled)
);
